// ===== rtl/line_sensor_pid_steering_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef LINE_SENSOR_PID_STEERING_UNIT_MACROS_SVH
`define LINE_SENSOR_PID_STEERING_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define LSP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequence is checked in the next cycle.
`define LSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/lsp_pkg.sv =====
// ----------------------------------------------------------------------------
// lsp_pkg
// Types and constants for the line-sensor PID steering unit.
// ----------------------------------------------------------------------------
package lsp_pkg;
  localparam int IntegWidth = 24;
  localparam int GainWidth = 26;
  localparam int QueueDepth = 2;

  localparam logic [1:0] ModeLine = 2'd0;
  localparam logic [1:0] ModeCorner = 2'd1;
  localparam logic [1:0] ModeLost = 2'd2;

  localparam logic [2:0] RegMaxOne = 3'd0;
  localparam logic [2:0] RegMaxTwo = 3'd1;
  localparam logic [2:0] RegMaxThree = 3'd2;
  localparam logic [2:0] RegMaxFour = 3'd3;
  localparam logic [2:0] RegGainProp = 3'd4;
  localparam logic [2:0] RegGainInteg = 3'd5;
  localparam logic [2:0] RegGainDeriv = 3'd6;

  typedef struct packed {
    logic signed [7:0] err;
    logic [1:0] mode;
    logic integ_clear;
  } cls_item_t;

  typedef enum logic [2:0] {
    FrIdle, FrDiv, FrClass, FrPush
  } front_state_t;

  typedef enum logic [2:0] {
    BkIdle, BkInteg, BkMul, BkSum, BkOut
  } back_state_t;
endpackage

// ===== rtl/lsp_front.sv =====
// ----------------------------------------------------------------------------
// lsp_front
// Scales the four readings to percent with a shared bit-serial divider,
// tracks the side of the line and classifies the item.
// ----------------------------------------------------------------------------
module lsp_front (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic ready,
  input  logic [7:0] raw_one,
  input  logic [7:0] raw_two,
  input  logic [7:0] raw_three,
  input  logic [7:0] raw_four,
  input  logic [7:0] max_one,
  input  logic [7:0] max_two,
  input  logic [7:0] max_three,
  input  logic [7:0] max_four,
  output logic push,
  input  logic full,
  output lsp_pkg::cls_item_t item
);
  lsp_pkg::front_state_t state, state_next;
  logic [7:0] raw [4];
  logic [6:0] pct [4];
  logic [1:0] sel;
  logic [3:0] bit_cnt;
  logic [14:0] dividend;
  logic [7:0] rem;
  logic [13:0] quo;
  logic mid_seen, last_left;
  logic [7:0] dvs;
  logic [8:0] trial;
  logic [8:0] rem_sh;
  logic lo0, lo1, lo2, lo3, hi0, hi1, hi2, hi3, ms, ll;
  logic signed [10:0] wsum;
  logic signed [10:0] wq;

  always_comb begin
    unique case (sel)
      2'd0: dvs = max_one;
      2'd1: dvs = max_two;
      2'd2: dvs = max_three;
      default: dvs = max_four;
    endcase
    rem_sh = {rem, dividend[14]};
    trial = rem_sh - {1'b0, dvs};
  end

  assign ready = (state == lsp_pkg::FrIdle);
  assign push = (state == lsp_pkg::FrPush) && !full;

  always_comb begin
    state_next = state;
    unique case (state)
      lsp_pkg::FrIdle: if (valid) state_next = lsp_pkg::FrDiv;
      lsp_pkg::FrDiv: if (bit_cnt == 4'd14 && sel == 2'd3) state_next = lsp_pkg::FrClass;
      lsp_pkg::FrClass: state_next = lsp_pkg::FrPush;
      lsp_pkg::FrPush: if (!full) state_next = lsp_pkg::FrIdle;
      default: state_next = lsp_pkg::FrIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsp_pkg::FrIdle;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    lo0 = pct[0] < 7'd40; lo1 = pct[1] < 7'd40;
    lo2 = pct[2] < 7'd40; lo3 = pct[3] < 7'd40;
    hi0 = pct[0] > 7'd80; hi1 = pct[1] > 7'd80;
    hi2 = pct[2] > 7'd80; hi3 = pct[3] > 7'd80;
    ms = mid_seen | lo1 | lo2;
    ll = last_left;
    if (ms && lo0) begin
      ll = 1'b0; ms = 1'b0;
    end else if (ms && lo3) begin
      ll = 1'b1; ms = 1'b0;
    end
    wsum = -11'sd3 * $signed({4'd0, pct[0]}) - $signed({4'd0, pct[1]})
           + $signed({4'd0, pct[2]}) + 11'sd3 * $signed({4'd0, pct[3]});
    wq = (wsum < 0) ? -((-wsum) >>> 2) : (wsum >>> 2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_seen <= 1'b0;
      last_left <= 1'b1;
    end else if (state == lsp_pkg::FrClass) begin
      mid_seen <= ms;
      last_left <= ll;
    end
  end

  always_ff @(posedge clk) begin
    if (state == lsp_pkg::FrIdle && valid) begin
      raw[0] <= raw_one; raw[1] <= raw_two; raw[2] <= raw_three; raw[3] <= raw_four;
      sel <= 2'd0;
      bit_cnt <= 4'd0;
      dividend <= {7'd0, raw_one} * 15'd100;
      rem <= 8'd0;
      quo <= 14'd0;
    end else if (state == lsp_pkg::FrDiv) begin
      if (bit_cnt == 4'd14) begin
        if (dvs == 8'd0 || {quo, !trial[8]} > 15'd100) pct[sel] <= 7'd100;
        else pct[sel] <= 7'({quo, !trial[8]});
        bit_cnt <= 4'd0;
        sel <= sel + 2'd1;
        rem <= 8'd0;
        quo <= 14'd0;
        dividend <= {7'd0, raw[2'(sel + 2'd1)]} * 15'd100;
      end else begin
        rem <= trial[8] ? rem_sh[7:0] : trial[7:0];
        quo <= {quo[12:0], !trial[8]};
        dividend <= {dividend[13:0], 1'b0};
        bit_cnt <= bit_cnt + 4'd1;
      end
    end else if (state == lsp_pkg::FrClass) begin
      if (!hi0 && !hi1 && !hi2 && !hi3 && !(pct[0] == 7'd80) && !(pct[1] == 7'd80)
          && !(pct[2] == 7'd80) && !(pct[3] == 7'd80)) begin
        item.err <= 8'sd0; item.mode <= lsp_pkg::ModeLine; item.integ_clear <= 1'b1;
      end else if (hi0 && hi1 && hi2 && hi3) begin
        item.err <= ll ? -8'sd100 : 8'sd100; item.mode <= lsp_pkg::ModeLost;
        item.integ_clear <= 1'b1;
      end else if (hi1 && hi2 && hi0) begin
        item.err <= -8'sd60; item.mode <= lsp_pkg::ModeCorner; item.integ_clear <= 1'b1;
      end else if (hi1 && hi2 && hi3) begin
        item.err <= 8'sd60; item.mode <= lsp_pkg::ModeCorner; item.integ_clear <= 1'b1;
      end else begin
        item.err <= 8'(wq); item.mode <= lsp_pkg::ModeLine; item.integ_clear <= 1'b0;
      end
    end
  end
endmodule

// ===== rtl/lsp_queue.sv =====
// ----------------------------------------------------------------------------
// lsp_queue
// Two-entry queue between the classifier and the PID datapath.
// ----------------------------------------------------------------------------
module lsp_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  lsp_pkg::cls_item_t push_item,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output lsp_pkg::cls_item_t pop_item
);
  lsp_pkg::cls_item_t mem [lsp_pkg::QueueDepth];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'(lsp_pkg::QueueDepth));
  assign nonempty = (count != 2'd0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0; rd_ptr <= 1'b0; count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

// ===== rtl/lsp_back.sv =====
// ----------------------------------------------------------------------------
// lsp_back
// Saturating integrator and PID sum with one shared multiplier.
// ----------------------------------------------------------------------------
module lsp_back (
  input  logic clk,
  input  logic rst,
  input  logic nonempty,
  input  lsp_pkg::cls_item_t item,
  output logic pop,
  input  logic [lsp_pkg::GainWidth-1:0] gain_prop,
  input  logic [lsp_pkg::GainWidth-1:0] gain_integ,
  input  logic [lsp_pkg::GainWidth-1:0] gain_deriv,
  output logic valid,
  input  logic ready,
  output logic signed [6:0] steer,
  output logic signed [7:0] position_error,
  output logic [1:0] track_mode
);
  localparam int IW = lsp_pkg::IntegWidth;
  localparam int AW = 44;
  localparam logic signed [AW-1:0] Lim = AW'(64'sd50 * 64'sd65536);
  localparam logic [41:0] TermLim = 42'd1 << 40;

  lsp_pkg::back_state_t state, state_next;
  logic signed [IW-1:0] integ;
  logic signed [7:0] prev_err, err;
  logic [1:0] mode;
  logic integ_clear;
  logic [1:0] term;
  logic signed [AW-1:0] acc;
  logic [IW:0] mag;
  logic neg;
  logic [lsp_pkg::GainWidth-1:0] gsel;
  logic [IW+lsp_pkg::GainWidth:0] prod;
  logic [41:0] psat;
  logic signed [IW+1:0] isum;
  logic signed [8:0] dval;
  logic signed [IW:0] opnd;
  logic signed [AW-1:0] clamped;
  logic [AW-1:0] absv;

  always_comb begin
    isum = $signed({{2{integ[IW-1]}}, integ}) + $signed({{(IW-6){err[7]}}, err});
    dval = $signed({err[7], err}) - $signed({prev_err[7], prev_err});
    unique case (term)
      2'd0: begin gsel = gain_prop; opnd = (IW+1)'(err); end
      2'd1: begin gsel = gain_integ; opnd = (IW+1)'(integ); end
      default: begin gsel = gain_deriv; opnd = (IW+1)'(dval); end
    endcase
    mag = opnd[IW] ? (IW+1)'(-opnd) : opnd;
    psat = (prod > (IW+lsp_pkg::GainWidth+1)'(TermLim)) ? TermLim : 42'(prod);
    clamped = (acc > Lim) ? Lim : ((acc < -Lim) ? -Lim : acc);
    absv = clamped[AW-1] ? AW'(-clamped) : clamped;
  end

  assign pop = (state == lsp_pkg::BkIdle) && nonempty;

  always_comb begin
    state_next = state;
    unique case (state)
      lsp_pkg::BkIdle: if (nonempty) state_next = lsp_pkg::BkInteg;
      lsp_pkg::BkInteg: state_next = lsp_pkg::BkMul;
      lsp_pkg::BkMul: state_next = lsp_pkg::BkSum;
      lsp_pkg::BkSum: state_next = (term == 2'd2) ? lsp_pkg::BkOut : lsp_pkg::BkMul;
      lsp_pkg::BkOut: if (!valid || ready) state_next = lsp_pkg::BkIdle;
      default: state_next = lsp_pkg::BkIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsp_pkg::BkIdle;
      valid <= 1'b0;
      integ <= '0;
      prev_err <= '0;
    end else begin
      state <= state_next;
      if (state == lsp_pkg::BkOut && (!valid || ready)) begin
        valid <= 1'b1;
        steer <= clamped[AW-1] ? -7'(absv >> 16) : 7'(absv >> 16);
        position_error <= err;
        track_mode <= mode;
        prev_err <= err;
      end else if (valid && ready) begin
        valid <= 1'b0;
      end
      if (state == lsp_pkg::BkIdle && nonempty) begin
        err <= item.err; mode <= item.mode; integ_clear <= item.integ_clear;
        term <= 2'd0; acc <= '0;
      end
      if (state == lsp_pkg::BkInteg) begin
        if (integ_clear) integ <= '0;
        else if (isum > $signed((IW+2)'({1'b0, {(IW-1){1'b1}}})))
          integ <= {1'b0, {(IW-1){1'b1}}};
        else if (isum < -$signed((IW+2)'({1'b1, {(IW-1){1'b0}}})))
          integ <= {1'b1, {(IW-1){1'b0}}};
        else integ <= IW'(isum);
      end
      if (state == lsp_pkg::BkMul) begin
        prod <= mag * gsel;
        neg <= opnd[IW];
      end
      if (state == lsp_pkg::BkSum) begin
        acc <= neg ? acc - AW'(psat) : acc + AW'(psat);
        term <= term + 2'd1;
      end
    end
  end
endmodule

// ===== rtl/line_sensor_pid_steering_unit.sv =====
// ----------------------------------------------------------------------------
// line_sensor_pid_steering_unit
// Line-sensor classification and fixed-point PID steering correction.
// ----------------------------------------------------------------------------
// Channel  Handshake        Payload
// input    valid / ready    raw_one, raw_two, raw_three, raw_four
// output   out_valid/ready  steer, position_error, track_mode
// config   cfg_we           cfg_index, cfg_data
// The front runs four 15-step serial divisions per item and takes no new item until it has pushed.
// The back makes three passes per item through one multiplier.
// Reset is synchronous; it restores the register defaults and clears the control state and the integrator.
// A stalled output holds the back; the queue lets the front run ahead.
module line_sensor_pid_steering_unit (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic ready,
  input  logic [7:0] raw_one,
  input  logic [7:0] raw_two,
  input  logic [7:0] raw_three,
  input  logic [7:0] raw_four,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [6:0] steer,
  output logic signed [7:0] position_error,
  output logic [1:0] track_mode,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [25:0] cfg_data
);
  logic [7:0] max_one, max_two, max_three, max_four;
  logic [25:0] gain_prop, gain_integ, gain_deriv;
  logic push, full, pop, nonempty;
  lsp_pkg::cls_item_t push_item, pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_one <= 8'd54; max_two <= 8'd44; max_three <= 8'd41; max_four <= 8'd50;
      gain_prop <= 26'd32768; gain_integ <= 26'd98; gain_deriv <= 26'd65536000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsp_pkg::RegMaxOne: max_one <= cfg_data[7:0];
        lsp_pkg::RegMaxTwo: max_two <= cfg_data[7:0];
        lsp_pkg::RegMaxThree: max_three <= cfg_data[7:0];
        lsp_pkg::RegMaxFour: max_four <= cfg_data[7:0];
        lsp_pkg::RegGainProp: gain_prop <= cfg_data;
        lsp_pkg::RegGainInteg: gain_integ <= cfg_data;
        lsp_pkg::RegGainDeriv: gain_deriv <= cfg_data;
        default: ;
      endcase
    end
  end

  lsp_front u_front (.clk, .rst, .valid, .ready, .raw_one, .raw_two, .raw_three,
    .raw_four, .max_one, .max_two, .max_three, .max_four, .push, .full,
    .item(push_item));
  lsp_queue u_queue (.clk, .rst, .push, .push_item, .full, .pop, .nonempty,
    .pop_item);
  lsp_back u_back (.clk, .rst, .nonempty, .item(pop_item), .pop, .gain_prop,
    .gain_integ, .gain_deriv, .valid(out_valid), .ready(out_ready), .steer,
    .position_error, .track_mode);
endmodule

// ===== rtl/lsp_checker.sv =====
// ----------------------------------------------------------------------------
// lsp_checker
// Port-level checks for the line-sensor PID steering unit.
// ----------------------------------------------------------------------------
`include "line_sensor_pid_steering_unit_macros.svh"
module lsp_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic signed [6:0] steer,
  input logic signed [7:0] position_error,
  input logic [1:0] track_mode
);
  `LSP_ASSERT_IMPL(a_steer_range, clk, rst, out_valid,
    steer <= 7'sd50 && steer >= -7'sd50, "steer out of range")
  `LSP_ASSERT_IMPL(a_mode_code, clk, rst, out_valid,
    track_mode <= lsp_pkg::ModeLost, "bad mode")
  `LSP_ASSERT_IMPL(a_lost_err, clk, rst, out_valid && track_mode == lsp_pkg::ModeLost,
    position_error == 8'sd100 || position_error == -8'sd100, "lost error")
  `LSP_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(steer), "stall drop")
endmodule

bind line_sensor_pid_steering_unit lsp_checker u_lsp_checker (.clk, .rst, .out_valid,
  .out_ready, .steer, .position_error, .track_mode);
